// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the cipher core.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/gbc_pkg.sv -----
// Shared types and constants for the GOST 28147-89 cipher core.
// No dependencies; used by gbc_round and gost_block_cipher_ecb_gamma.
package gbc_pkg;

  localparam int unsigned ROUNDS_DEF = 32;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned BLOCK_W    = 64;
  localparam int unsigned NIBBLES    = 8;
  localparam int unsigned ROT_L      = 11;
  localparam int unsigned CFG_ADDR_W = 3;

  localparam logic [WORD_W-1:0] STEP_HIGH_RST = 32'h0101_0101;
  localparam logic [WORD_W-1:0] STEP_LOW_RST  = 32'h0101_0104;

  typedef enum logic [2:0] {
    OP_LOAD_ROW = 3'd0,
    OP_ENCRYPT  = 3'd1,
    OP_DECRYPT  = 3'd2,
    OP_G_START  = 3'd3,
    OP_G_BLOCK  = 3'd4
  } op_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_KEY_01    = 3'd0,
    CFG_KEY_23    = 3'd1,
    CFG_KEY_45    = 3'd2,
    CFG_KEY_67    = 3'd3,
    CFG_STEP_HIGH = 3'd4,
    CFG_STEP_LOW  = 3'd5
  } cfg_addr_t;

  typedef logic [NIBBLES-1:0][BLOCK_W-1:0] sbox_t;

endpackage

// ----- rtl/core/gbc_round.sv -----
// One Feistel round of GOST 28147-89: key add, nibble substitution,
// rotate left, XOR with the other half. Depends on gbc_pkg.
module gbc_round (
  input  logic [gbc_pkg::WORD_W-1:0] half_a,
  input  logic [gbc_pkg::WORD_W-1:0] half_b,
  input  logic [gbc_pkg::WORD_W-1:0] key_word,
  input  gbc_pkg::sbox_t             sbox_rows,
  output logic [gbc_pkg::WORD_W-1:0] round_out
);

  logic [gbc_pkg::WORD_W-1:0] sum;
  logic [gbc_pkg::WORD_W-1:0] sub;

  assign sum = half_a + key_word;

  // Nibble p looks up row p; each row holds 16 four-bit entries.
  always_comb begin
    for (int p = 0; p < gbc_pkg::NIBBLES; p++) begin
      sub[4*p +: 4] = sbox_rows[p][4*sum[4*p +: 4] +: 4];
    end
  end

  assign round_out = {sub[gbc_pkg::WORD_W-gbc_pkg::ROT_L-1:0],
                      sub[gbc_pkg::WORD_W-1:gbc_pkg::WORD_W-gbc_pkg::ROT_L]} ^ half_b;

endmodule

// ----- rtl/core/gost_block_cipher_ecb_gamma.sv -----
// GOST 28147-89 block cipher core: ECB encrypt/decrypt and gamma (counter) mode.
// Rounds: one round per cycle through the single shared round unit; out_tvalid
//   is registered when the last round completes, and the last round of an op that
//   returns a result holds while an earlier result still waits in the output register.
// Flow: in_tready is low while running, so one item finishes before the next;
//   row loads and unused opcodes are taken in idle and produce no transfer.
// Reset (rst_n, synchronous, active low): clear key, rows and counters, set the
//   gamma step registers to their defaults, drop any pending result.
`include "assert_macros.svh"

module gost_block_cipher_ecb_gamma #(
  parameter int unsigned ROUNDS = gbc_pkg::ROUNDS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration write port
  input  logic                              cfg_we,
  input  logic [gbc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [gbc_pkg::BLOCK_W-1:0]       cfg_wdata,
  // Input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [gbc_pkg::BLOCK_W-1:0]       in_tdata,   // [63:0] block_data
  input  logic [5:0]                        in_tuser,   // [2:0] opcode, [5:3] row_index
  // Result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [gbc_pkg::BLOCK_W-1:0]       out_tdata   // [63:0] result_block
);

  localparam int unsigned RND_W = $clog2(ROUNDS);
  localparam int unsigned W     = gbc_pkg::WORD_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  // Control and configuration registers
  state_t                      state_r,   state_nxt;
  logic [RND_W-1:0]            rnd_r,     rnd_nxt;
  gbc_pkg::op_t                op_r,      op_nxt;
  logic [3:0][gbc_pkg::BLOCK_W-1:0] key_r, key_nxt;
  logic [W-1:0]                step_hi_r, step_hi_nxt;
  logic [W-1:0]                step_lo_r, step_lo_nxt;
  gbc_pkg::sbox_t              sbox_r,    sbox_nxt;
  logic [W-1:0]                ctr_lo_r,  ctr_lo_nxt;
  logic [W-1:0]                ctr_hi_r,  ctr_hi_nxt;
  logic [W-1:0]                half_a_r,  half_a_nxt;
  logic [W-1:0]                half_b_r,  half_b_nxt;
  logic [gbc_pkg::BLOCK_W-1:0] data_r,    data_nxt;
  logic                        out_vld_r, out_vld_nxt;
  logic [gbc_pkg::BLOCK_W-1:0] out_data_r, out_data_nxt;

  // Datapath helpers
  gbc_pkg::op_t                in_op;
  logic [2:0]                  in_row;
  logic                        accept;
  logic                        last_rnd;
  logic                        out_busy;
  logic                        need_out;
  logic                        fwd;
  logic [2:0]                  kidx;
  logic [gbc_pkg::BLOCK_W-1:0] kpair;
  logic [W-1:0]                key_word;
  logic [W-1:0]                round_out;
  logic [W-1:0]                ctr_lo_step;
  logic [W:0]                  hi_sum;
  logic [W-1:0]                ctr_hi_step;
  logic [gbc_pkg::BLOCK_W-1:0] cipher_out;

  assign in_op    = gbc_pkg::op_t'(in_tuser[2:0]);
  assign in_row   = in_tuser[5:3];
  assign in_tready = (state_r == S_IDLE);
  assign accept   = in_tvalid && in_tready;
  assign last_rnd = (rnd_r == RND_W'(ROUNDS - 1));
  assign out_busy = out_vld_r && !out_tready;
  assign need_out = (op_r == gbc_pkg::OP_ENCRYPT) || (op_r == gbc_pkg::OP_DECRYPT) ||
                    (op_r == gbc_pkg::OP_G_BLOCK);

  // Key order: forward for the first three octets on encrypt, for the first
  // octet only on decrypt; reversed octets count key words down from seven.
  assign fwd      = (op_r == gbc_pkg::OP_DECRYPT) ? (rnd_r < RND_W'(8))
                                                  : (rnd_r < RND_W'(ROUNDS - 8));
  assign kidx     = fwd ? rnd_r[2:0] : ~rnd_r[2:0];
  assign kpair    = key_r[kidx[2:1]];
  assign key_word = kidx[0] ? kpair[2*W-1:W] : kpair[W-1:0];

  gbc_round u_round (
    .half_a    (half_a_r),
    .half_b    (half_b_r),
    .key_word  (key_word),
    .sbox_rows (sbox_r),
    .round_out (round_out)
  );

  // Final round leaves half A in place and writes the new value to half B.
  assign cipher_out = {round_out, half_a_r};

  // Counter step: low half wraps mod 2^32, high half with end-around carry.
  assign ctr_lo_step = ctr_lo_r + step_lo_r;
  assign hi_sum      = {1'b0, ctr_hi_r} + {1'b0, step_hi_r};
  assign ctr_hi_step = hi_sum[W-1:0] + {{(W-1){1'b0}}, hi_sum[W]};

  always_comb begin
    state_nxt    = state_r;
    rnd_nxt      = rnd_r;
    op_nxt       = op_r;
    key_nxt      = key_r;
    step_hi_nxt  = step_hi_r;
    step_lo_nxt  = step_lo_r;
    sbox_nxt     = sbox_r;
    ctr_lo_nxt   = ctr_lo_r;
    ctr_hi_nxt   = ctr_hi_r;
    half_a_nxt   = half_a_r;
    half_b_nxt   = half_b_r;
    data_nxt     = data_r;
    out_data_nxt = out_data_r;
    out_vld_nxt  = out_vld_r && !out_tready;

    // Configuration writes; addresses past the list are dropped.
    if (cfg_we) begin
      unique case (gbc_pkg::cfg_addr_t'(cfg_addr))
        gbc_pkg::CFG_KEY_01:    key_nxt[0]  = cfg_wdata;
        gbc_pkg::CFG_KEY_23:    key_nxt[1]  = cfg_wdata;
        gbc_pkg::CFG_KEY_45:    key_nxt[2]  = cfg_wdata;
        gbc_pkg::CFG_KEY_67:    key_nxt[3]  = cfg_wdata;
        gbc_pkg::CFG_STEP_HIGH: step_hi_nxt = cfg_wdata[W-1:0];
        gbc_pkg::CFG_STEP_LOW:  step_lo_nxt = cfg_wdata[W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt   = in_op;
          rnd_nxt  = '0;
          data_nxt = in_tdata;
          case (in_op) inside
            gbc_pkg::OP_LOAD_ROW: sbox_nxt[in_row] = in_tdata;
            gbc_pkg::OP_ENCRYPT, gbc_pkg::OP_DECRYPT, gbc_pkg::OP_G_START: begin
              half_a_nxt = in_tdata[W-1:0];
              half_b_nxt = in_tdata[2*W-1:W];
              state_nxt  = S_RUN;
            end
            gbc_pkg::OP_G_BLOCK: begin
              ctr_lo_nxt = ctr_lo_step;
              ctr_hi_nxt = ctr_hi_step;
              half_a_nxt = ctr_lo_step;
              half_b_nxt = ctr_hi_step;
              state_nxt  = S_RUN;
            end
            default: ;
          endcase
        end
      end
      S_RUN: begin
        if (!last_rnd) begin
          half_b_nxt = half_a_r;
          half_a_nxt = round_out;
          rnd_nxt    = rnd_r + RND_W'(1);
        end else if (!(need_out && out_busy)) begin
          // Result-producing ops hold on the last round until the output register is free.
          half_b_nxt = round_out;
          state_nxt  = S_IDLE;
          if (op_r == gbc_pkg::OP_G_START) begin
            ctr_lo_nxt = cipher_out[W-1:0];
            ctr_hi_nxt = cipher_out[2*W-1:W];
          end else begin
            out_vld_nxt  = 1'b1;
            out_data_nxt = (op_r == gbc_pkg::OP_G_BLOCK) ? (data_r ^ cipher_out)
                                                         : cipher_out;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      rnd_r     <= '0;
      op_r      <= gbc_pkg::OP_LOAD_ROW;
      key_r     <= '0;
      step_hi_r <= gbc_pkg::STEP_HIGH_RST;
      step_lo_r <= gbc_pkg::STEP_LOW_RST;
      sbox_r    <= '0;
      ctr_lo_r  <= '0;
      ctr_hi_r  <= '0;
      half_a_r  <= '0;
      half_b_r  <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rnd_r     <= rnd_nxt;
      op_r      <= op_nxt;
      key_r     <= key_nxt;
      step_hi_r <= step_hi_nxt;
      step_lo_r <= step_lo_nxt;
      sbox_r    <= sbox_nxt;
      ctr_lo_r  <= ctr_lo_nxt;
      ctr_hi_r  <= ctr_hi_nxt;
      half_a_r  <= half_a_nxt;
      half_b_r  <= half_b_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r     <= data_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // Checks
  `ASSERT_SAME(a_state_onehot, clk, rst_n, 1'b1, $onehot(state_r), "state not one-hot")
  `ASSERT_SAME(a_out_from_run, clk, rst_n, $rose(out_vld_r), $past(state_r) == S_RUN, "result without cipher run")
  `ASSERT_NEXT(a_rnd_advance, clk, rst_n, state_r == S_RUN && !last_rnd, rnd_r == $past(rnd_r) + RND_W'(1), "round counter did not advance")
  `ASSERT_NEXT(a_start_no_out, clk, rst_n, accept && in_op == gbc_pkg::OP_LOAD_ROW, state_r == S_IDLE, "row load left idle")

endmodule
